@@ hw/rtl/lfmq_pkg.sv @@
// Package for the lap finish marker qualifier: operation and phase codes,
// register indexes and the item, result and configuration types.
// No dependencies; used by every other file of the block but lfmq_ifs.
package lfmq_pkg;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;
  localparam logic [1:0] OP_ABORT = 2'd3;

  localparam logic [1:0] PH_IDLE     = 2'd0;
  localparam logic [1:0] PH_ACTIVE   = 2'd1;
  localparam logic [1:0] PH_COMPLETE = 2'd2;

  localparam int unsigned PADDR_W = 4;
  localparam logic [1:0] REG_CLEAR_SAMPLES   = 2'd0;
  localparam logic [1:0] REG_CONFIRM_SAMPLES = 2'd1;
  localparam logic [1:0] REG_MIN_LAP_MS      = 2'd2;

  localparam logic [7:0]  CLEAR_SAMPLES_RST   = 8'd10;
  localparam logic [7:0]  CONFIRM_SAMPLES_RST = 8'd3;
  localparam logic [19:0] MIN_LAP_MS_RST      = 20'd3000;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] now_ms;
    logic        marker_seen;
    logic        line_visible;
  } in_item_t;

  typedef struct packed {
    logic        running;
    logic        finished_now;
    logic [31:0] elapsed_ms;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  clear_samples;
    logic [7:0]  confirm_samples;
    logic [19:0] min_lap_ms;
  } cfg_t;

endpackage

@@ hw/rtl/lfmq_ifs.sv @@
// Valid/ready channel interfaces for the lap finish marker qualifier:
// one for sensor operations in, one for run status out.
// No dependencies.
interface lfmq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] now_ms;
  logic        marker_seen;
  logic        line_visible;

  modport source (output valid, operation, now_ms, marker_seen, line_visible, input ready);
  modport sink (input valid, operation, now_ms, marker_seen, line_visible, output ready);
endinterface

interface lfmq_out_if;
  logic        valid;
  logic        ready;
  logic        running;
  logic        finished_now;
  logic [31:0] elapsed_ms;

  modport source (output valid, running, finished_now, elapsed_ms, input ready);
  modport sink (input valid, running, finished_now, elapsed_ms, output ready);
endinterface

@@ hw/rtl/lap_finish_marker_qualifier.sv @@
// Lap finish marker qualifier. Each operation transfer on in_ch (sensor tick, start,
// stop or abort, with a millisecond timestamp) produces exactly one status transfer
// on out_ch giving running, finished_now and elapsed time. One operation is taken
// every clock cycle; each result passes through the input register and then the
// result register, with the run state updated as the item moves from the first
// to the second. Back-pressure on out_ch stalls the input only once both registers
// hold an item. Thresholds are to be written by the user through the APB port only
// while no operation is in flight; the block itself does not enforce this.
// Depends on lfmq_pkg, lfmq_ifs, lfmq_cfg_regs and lfmq_run_core.
module lap_finish_marker_qualifier (
  input  logic                         clk,
  input  logic                         rst_n,
  lfmq_in_if.sink                      in_ch,
  lfmq_out_if.source                   out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lfmq_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  lfmq_pkg::cfg_t      cfg;
  lfmq_pkg::in_item_t  in_item_r;
  lfmq_pkg::out_item_t out_item_r;
  lfmq_pkg::out_item_t result;
  logic                in_vld_r;
  logic                out_vld_r;
  logic                advance;
  logic                in_xfer;

  lfmq_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lfmq_run_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (in_item_r),
    .cfg    (cfg),
    .result (result)
  );

  assign advance     = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || advance;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_xfer) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_item_r.operation    <= in_ch.operation;
      in_item_r.now_ms       <= in_ch.now_ms;
      in_item_r.marker_seen  <= in_ch.marker_seen;
      in_item_r.line_visible <= in_ch.line_visible;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= result;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.running      = out_item_r.running;
  assign out_ch.finished_now = out_item_r.finished_now;
  assign out_ch.elapsed_ms   = out_item_r.elapsed_ms;

endmodule

@@ hw/rtl/lfmq_cfg_regs.sv @@
// APB-style configuration registers of the lap finish marker qualifier.
// Depends on lfmq_pkg.
module lfmq_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lfmq_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output lfmq_pkg::cfg_t               cfg
);

  lfmq_pkg::cfg_t cfg_r;
  logic           wr_en;
  logic [1:0]     reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.clear_samples   <= lfmq_pkg::CLEAR_SAMPLES_RST;
      cfg_r.confirm_samples <= lfmq_pkg::CONFIRM_SAMPLES_RST;
      cfg_r.min_lap_ms      <= lfmq_pkg::MIN_LAP_MS_RST;
    end else if (wr_en) begin
      case (reg_idx)
        lfmq_pkg::REG_CLEAR_SAMPLES:   cfg_r.clear_samples   <= pwdata[7:0];
        lfmq_pkg::REG_CONFIRM_SAMPLES: cfg_r.confirm_samples <= pwdata[7:0];
        lfmq_pkg::REG_MIN_LAP_MS:      cfg_r.min_lap_ms      <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      lfmq_pkg::REG_CLEAR_SAMPLES:   prdata = {24'd0, cfg_r.clear_samples};
      lfmq_pkg::REG_CONFIRM_SAMPLES: prdata = {24'd0, cfg_r.confirm_samples};
      lfmq_pkg::REG_MIN_LAP_MS:      prdata = {12'd0, cfg_r.min_lap_ms};
      default:                       prdata = 32'd0;
    endcase
  end

endmodule

@@ hw/rtl/lfmq_run_core.sv @@
// Run state of the lap finish marker qualifier: phase, start and finish times,
// arming and confirmation counters, and the result of the item being stepped.
// Depends on lfmq_pkg.
module lfmq_run_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  lfmq_pkg::in_item_t  item,
  input  lfmq_pkg::cfg_t      cfg,
  output lfmq_pkg::out_item_t result
);

  logic [1:0]  phase_r, phase_nxt;
  logic [31:0] start_r, start_nxt;
  logic [31:0] finish_r, finish_nxt;
  logic        armed_r, armed_nxt;
  logic        latched_r, latched_nxt;
  logic [7:0]  confirm_r, confirm_nxt;
  logic [7:0]  clear_r, clear_nxt;

  logic [7:0]  clear_inc;
  logic [7:0]  confirm_upd;
  logic        latch_kept;
  logic [31:0] since_start;
  logic        lap_ok;
  logic        done;

  // Counters saturate at their thresholds, so the increments cannot wrap.
  assign clear_inc = (clear_r < cfg.clear_samples) ? clear_r + 8'd1 : clear_r;
  assign since_start = item.now_ms - start_r;
  assign lap_ok = since_start >= {12'd0, cfg.min_lap_ms};

  always_comb begin
    if (!item.marker_seen) begin
      confirm_upd = 8'd0;
      latch_kept  = 1'b0;
    end else begin
      confirm_upd = (confirm_r < cfg.confirm_samples) ? confirm_r + 8'd1 : confirm_r;
      latch_kept  = latched_r;
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    start_nxt   = start_r;
    finish_nxt  = finish_r;
    armed_nxt   = armed_r;
    latched_nxt = latched_r;
    confirm_nxt = confirm_r;
    clear_nxt   = clear_r;
    done        = 1'b0;
    case (item.operation)
      lfmq_pkg::OP_TICK: begin
        if (phase_r == lfmq_pkg::PH_ACTIVE) begin
          if (!armed_r) begin
            confirm_nxt = 8'd0;
            if (!item.marker_seen && item.line_visible) begin
              clear_nxt = clear_inc;
              if (clear_inc >= cfg.clear_samples) begin
                armed_nxt   = 1'b1;
                latched_nxt = 1'b0;
              end
            end else begin
              clear_nxt = 8'd0;
            end
          end else begin
            confirm_nxt = confirm_upd;
            latched_nxt = latch_kept;
            if (!latch_kept && confirm_upd >= cfg.confirm_samples && lap_ok) begin
              latched_nxt = 1'b1;
              finish_nxt  = item.now_ms;
              phase_nxt   = lfmq_pkg::PH_COMPLETE;
              done        = 1'b1;
            end
          end
        end
      end
      lfmq_pkg::OP_START: begin
        if (phase_r != lfmq_pkg::PH_ACTIVE) begin
          start_nxt   = item.now_ms;
          finish_nxt  = item.now_ms;
          latched_nxt = 1'b0;
          confirm_nxt = 8'd0;
          clear_nxt   = 8'd0;
          armed_nxt   = 1'b0;
          phase_nxt   = lfmq_pkg::PH_ACTIVE;
        end
      end
      lfmq_pkg::OP_STOP: begin
        if (phase_r == lfmq_pkg::PH_ACTIVE) begin
          finish_nxt = item.now_ms;
          phase_nxt  = lfmq_pkg::PH_COMPLETE;
        end
      end
      default: phase_nxt = lfmq_pkg::PH_IDLE;
    endcase
  end

  always_comb begin
    result.running      = (phase_nxt == lfmq_pkg::PH_ACTIVE);
    result.finished_now = done;
    if (phase_nxt == lfmq_pkg::PH_ACTIVE) begin
      result.elapsed_ms = item.now_ms - start_nxt;
    end else begin
      result.elapsed_ms = finish_nxt - start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= lfmq_pkg::PH_IDLE;
      start_r   <= 32'd0;
      finish_r  <= 32'd0;
      armed_r   <= 1'b0;
      latched_r <= 1'b0;
      confirm_r <= 8'd0;
      clear_r   <= 8'd0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      start_r   <= start_nxt;
      finish_r  <= finish_nxt;
      armed_r   <= armed_nxt;
      latched_r <= latched_nxt;
      confirm_r <= confirm_nxt;
      clear_r   <= clear_nxt;
    end
  end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the lap finish marker qualifier: directed and random operation
// streams, an in-bench status predictor, and random stalls on both channels.
// Depends on lfmq_pkg, lfmq_ifs and lap_finish_marker_qualifier from hw/rtl.
module tb_top;
  import lfmq_pkg::*;

  localparam int WATCHDOG_CYCLES = 2000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int RANDOM_PHASE_ITEMS = 70;

  logic clk = 1'b0;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  lfmq_in_if op_if ();
  lfmq_out_if status_if ();

  lap_finish_marker_qualifier DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (op_if),
    .out_ch  (status_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: thresholds and the run controller as the block should hold them.
  cfg_t        lap_cfg;
  logic [1:0]  lap_phase;
  logic [31:0] lap_start_ms;
  logic [31:0] lap_finish_ms;
  logic        finish_armed;
  logic        finish_latched;
  logic [7:0]  marker_run;
  logic [7:0]  clear_run;

  out_item_t expected_status_q[$];

  int fail_count = 0;
  int items_sent = 0;
  int status_seen = 0;
  int laps_finished = 0;
  int settings_used = 0;
  int quiet_cycles = 0;
  int hold_left = 0;
  bit in_gaps_on = 1'b0;
  bit out_stall_on = 1'b0;
  logic [31:0] track_ms;

  function automatic logic tick_qualify(logic [31:0] now, logic marker, logic visible);
    logic [31:0] since_start;
    since_start = now - lap_start_ms;
    if (!finish_armed) begin
      marker_run = 8'd0;
      if (!marker && visible) begin
        if (clear_run < lap_cfg.clear_samples) clear_run = clear_run + 8'd1;
        if (clear_run >= lap_cfg.clear_samples) begin
          finish_armed = 1'b1;
          finish_latched = 1'b0;
        end
      end else begin
        clear_run = 8'd0;
      end
      return 1'b0;
    end
    if (!marker) begin
      finish_latched = 1'b0;
      marker_run = 8'd0;
    end else if (marker_run < lap_cfg.confirm_samples) begin
      marker_run = marker_run + 8'd1;
    end
    if (!finish_latched && marker_run >= lap_cfg.confirm_samples &&
        since_start >= {12'd0, lap_cfg.min_lap_ms}) begin
      finish_latched = 1'b1;
      lap_finish_ms = now;
      lap_phase = PH_COMPLETE;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic out_item_t predict_status(in_item_t op);
    out_item_t st;
    logic done;
    done = 1'b0;
    case (op.operation)
      OP_TICK: begin
        if (lap_phase == PH_ACTIVE) done = tick_qualify(op.now_ms, op.marker_seen, op.line_visible);
      end
      OP_START: begin
        if (lap_phase != PH_ACTIVE) begin
          lap_start_ms = op.now_ms;
          lap_finish_ms = op.now_ms;
          finish_latched = 1'b0;
          marker_run = 8'd0;
          clear_run = 8'd0;
          finish_armed = 1'b0;
          lap_phase = PH_ACTIVE;
        end
      end
      OP_STOP: begin
        if (lap_phase == PH_ACTIVE) begin
          lap_finish_ms = op.now_ms;
          lap_phase = PH_COMPLETE;
        end
      end
      default: lap_phase = PH_IDLE;
    endcase
    st.running = (lap_phase == PH_ACTIVE);
    st.finished_now = done;
    st.elapsed_ms = st.running ? op.now_ms - lap_start_ms : lap_finish_ms - lap_start_ms;
    return st;
  endfunction

  task automatic send_op(logic [1:0] opcode, logic [31:0] now, logic marker, logic visible);
    in_item_t op;
    op.operation = opcode;
    op.now_ms = now;
    op.marker_seen = marker;
    op.line_visible = visible;
    while (in_gaps_on && $urandom_range(0, 99) < 25) begin
      op_if.valid <= 1'b0;
      @(posedge clk);
    end
    op_if.valid <= 1'b1;
    op_if.operation <= opcode;
    op_if.now_ms <= now;
    op_if.marker_seen <= marker;
    op_if.line_visible <= visible;
    @(posedge clk);
    while (!op_if.ready) @(posedge clk);
    expected_status_q.push_back(predict_status(op));
    items_sent++;
  endtask

  // Every operation yields a status, so an empty queue plus a few cycles means idle.
  task automatic drain_results();
    op_if.valid <= 1'b0;
    while (expected_status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] index, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'({index, 2'b00});
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (index)
      REG_CLEAR_SAMPLES:   lap_cfg.clear_samples = value[7:0];
      REG_CONFIRM_SAMPLES: lap_cfg.confirm_samples = value[7:0];
      REG_MIN_LAP_MS:      lap_cfg.min_lap_ms = value[19:0];
      default: ;
    endcase
  endtask

  task automatic set_thresholds(logic [7:0] clear_n, logic [7:0] confirm_n, logic [19:0] min_ms);
    drain_results();
    write_reg(REG_CLEAR_SAMPLES, {24'd0, clear_n});
    write_reg(REG_CONFIRM_SAMPLES, {24'd0, confirm_n});
    write_reg(REG_MIN_LAP_MS, {12'd0, min_ms});
    settings_used++;
  endtask

  task automatic check_status();
    out_item_t want;
    status_seen++;
    if (status_if.finished_now) laps_finished++;
    if (expected_status_q.size() == 0) begin
      $display("%0t: status transfer with nothing expected (running %0b, finished %0b, elapsed %0d)",
               $time, status_if.running, status_if.finished_now, status_if.elapsed_ms);
      fail_count++;
      return;
    end
    want = expected_status_q.pop_front();
    if (status_if.running !== want.running) begin
      $display("%0t: running expected %0b, got %0b", $time, want.running, status_if.running);
      fail_count++;
    end
    if (status_if.finished_now !== want.finished_now) begin
      $display("%0t: finished_now expected %0b, got %0b", $time, want.finished_now,
               status_if.finished_now);
      fail_count++;
    end
    if (status_if.elapsed_ms !== want.elapsed_ms) begin
      $display("%0t: elapsed_ms expected %0d, got %0d", $time, want.elapsed_ms,
               status_if.elapsed_ms);
      fail_count++;
    end
  endtask

  // Status sink: checks each transfer and decides ready for the next cycle.
  always @(posedge clk) begin
    if (rst_n && status_if.valid && status_if.ready) check_status();
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      status_if.ready <= 1'b0;
    end else if (out_stall_on) begin
      status_if.ready <= ($urandom_range(0, 99) >= 25);
    end else begin
      status_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (op_if.valid && op_if.ready) || (status_if.valid && status_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("%0t: no transfer for %0d cycles, %0d statuses outstanding", $time,
               WATCHDOG_CYCLES, expected_status_q.size());
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_default_thresholds();
    send_op(OP_TICK, 32'hFFFF_FFFF, 1'b1, 1'b1);
    send_op(OP_STOP, 32'd10, 1'b0, 1'b0);
    send_op(OP_ABORT, 32'd20, 1'b1, 1'b0);
    send_op(OP_START, 32'd1000, 1'b0, 1'b1);
    send_op(OP_START, 32'd1500, 1'b1, 1'b1);
    for (int i = 0; i < 4; i++) send_op(OP_TICK, 32'd1010 + i, 1'b0, 1'b1);
    // A marker or a lost line before arming restarts the clear count.
    send_op(OP_TICK, 32'd1020, 1'b1, 1'b1);
    send_op(OP_TICK, 32'd1021, 1'b0, 1'b0);
    for (int i = 0; i < 10; i++) send_op(OP_TICK, 32'd1030 + i, 1'b0, 1'b1);
    send_op(OP_TICK, 32'd1200, 1'b1, 1'b0);
    send_op(OP_TICK, 32'd1210, 1'b0, 1'b1);
    for (int i = 0; i < 4; i++) send_op(OP_TICK, 32'd1300 + i, 1'b1, 1'b1);
    send_op(OP_TICK, 32'd3999, 1'b1, 1'b1);
    send_op(OP_TICK, 32'd4000, 1'b1, 1'b1);
    send_op(OP_TICK, 32'd4001, 1'b1, 1'b1);
    send_op(OP_STOP, 32'd4002, 1'b0, 1'b1);
    send_op(OP_START, 32'd5000, 1'b0, 1'b1);
    send_op(OP_STOP, 32'd5100, 1'b0, 1'b1);
    send_op(OP_ABORT, 32'd5200, 1'b0, 1'b1);
    send_op(OP_START, 32'd6000, 1'b0, 1'b1);
    send_op(OP_ABORT, 32'd6001, 1'b0, 1'b1);
  endtask

  task automatic test_zero_thresholds();
    set_thresholds(8'd0, 8'd0, 20'd0);
    send_op(OP_START, 32'h8000_0000, 1'b0, 1'b1);
    send_op(OP_TICK, 32'h8000_0001, 1'b1, 1'b1);
    send_op(OP_TICK, 32'h8000_0002, 1'b0, 1'b0);
    send_op(OP_TICK, 32'h8000_0003, 1'b0, 1'b1);
    // Armed with no confirm count needed: the next tick finishes even without a marker.
    send_op(OP_TICK, 32'h8000_0003, 1'b0, 1'b1);
    send_op(OP_TICK, 32'h8000_0004, 1'b1, 1'b1);
    send_op(OP_START, 32'h7FFF_FFFF, 1'b1, 1'b0);
    send_op(OP_TICK, 32'h7FFF_FFFF, 1'b0, 1'b1);
    send_op(OP_TICK, 32'h8000_0000, 1'b1, 1'b0);
  endtask

  task automatic test_max_thresholds();
    logic [31:0] t0;
    t0 = 32'hFFFF_FF00;
    set_thresholds(8'd255, 8'd255, 20'hFFFFF);
    send_op(OP_START, t0, 1'b0, 1'b1);
    for (int i = 1; i <= 255; i++) send_op(OP_TICK, t0 + i, 1'b0, 1'b1);
    for (int i = 0; i < 256; i++) send_op(OP_TICK, t0 + 1000 + i, 1'b1, 1'b1);
    send_op(OP_TICK, t0 + 32'd1048574, 1'b1, 1'b1);
    send_op(OP_TICK, t0 + 32'd1048575, 1'b1, 1'b1);
    send_op(OP_TICK, t0 + 32'd1048576, 1'b1, 1'b1);
  endtask

  task automatic test_hold_off();
    drain_results();
    in_gaps_on = 1'b0;
    out_stall_on = 1'b0;
    set_thresholds(8'd2, 8'd1, 20'd50);
    hold_left = HOLD_OFF_CYCLES;
    track_ms = 32'd100;
    send_op(OP_START, track_ms, 1'b0, 1'b1);
    for (int i = 0; i < 40; i++) begin
      track_ms = track_ms + 32'd7;
      send_op(OP_TICK, track_ms, (i % 5) == 4, 1'b1);
    end
    // Sender waits for every status before continuing.
    drain_results();
    in_gaps_on = 1'b1;
    out_stall_on = 1'b1;
    for (int i = 0; i < 10; i++) begin
      track_ms = track_ms + 32'd30;
      send_op(OP_TICK, track_ms, 1'b1, 1'b0);
    end
  endtask

  task automatic lap_tick(logic marker, logic visible);
    track_ms = track_ms + $urandom_range(0, 400);
    if ($urandom_range(0, 99) < 8) begin
      send_op(2'($urandom_range(0, 3)), ($urandom_range(0, 1) != 0) ? $urandom() : track_ms,
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end else begin
      send_op(OP_TICK, track_ms, marker, visible);
    end
  endtask

  // One lap: start, enough clean line to arm, then a marker run; ticks are sometimes replaced by random operations.
  task automatic random_lap();
    int n_clean;
    int n_mark;
    if ($urandom_range(0, 99) < 20) track_ms = $urandom();
    else track_ms = track_ms + $urandom_range(1, 5000);
    send_op(OP_START, track_ms, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    n_clean = lap_cfg.clear_samples + $urandom_range(0, 3);
    repeat (n_clean) lap_tick(1'b0, 1'b1);
    if ($urandom_range(0, 99) < 30) track_ms = track_ms + lap_cfg.min_lap_ms;
    n_mark = lap_cfg.confirm_samples + $urandom_range(0, 4);
    repeat (n_mark) lap_tick(1'b1, 1'($urandom_range(0, 1)));
    case ($urandom_range(0, 9))
      0, 1: send_op(OP_STOP, track_ms + $urandom_range(0, 50), 1'b0, 1'b1);
      2, 3: send_op(OP_ABORT, track_ms + $urandom_range(0, 50), 1'b0, 1'b1);
      default: ;
    endcase
  endtask

  task automatic test_random_laps();
    int target;
    for (int phase = 0; phase < 4; phase++) begin
      // The first phase runs with no idling on either side.
      in_gaps_on = (phase != 0);
      out_stall_on = (phase != 0);
      set_thresholds(8'($urandom_range(0, 12)), 8'($urandom_range(0, 8)),
                     ($urandom_range(0, 99) < 70) ? 20'($urandom_range(0, 3000))
                                                  : 20'($urandom_range(0, 20'hFFFFF)));
      target = items_sent + RANDOM_PHASE_ITEMS;
      while (items_sent < target) random_lap();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    op_if.valid = 1'b0;
    op_if.operation = OP_TICK;
    op_if.now_ms = '0;
    op_if.marker_seen = 1'b0;
    op_if.line_visible = 1'b0;
    status_if.ready = 1'b0;
    lap_cfg.clear_samples = CLEAR_SAMPLES_RST;
    lap_cfg.confirm_samples = CONFIRM_SAMPLES_RST;
    lap_cfg.min_lap_ms = MIN_LAP_MS_RST;
    lap_phase = PH_IDLE;
    lap_start_ms = '0;
    lap_finish_ms = '0;
    finish_armed = 1'b0;
    finish_latched = 1'b0;
    marker_run = '0;
    clear_run = '0;
    track_ms = '0;
    settings_used = 1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_thresholds();
    test_zero_thresholds();
    test_max_thresholds();
    test_hold_off();
    test_random_laps();

    drain_results();
    $display("Sent %0d operations and checked %0d status transfers, %0d of them lap finishes,",
             items_sent, status_seen, laps_finished);
    $display("over %0d threshold settings including all-zero and all-maximum.", settings_used);
    if (fail_count == 0 && expected_status_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/lfmq_pkg.sv
hw/rtl/lfmq_ifs.sv
hw/rtl/lfmq_cfg_regs.sv
hw/rtl/lfmq_run_core.sv
hw/rtl/lap_finish_marker_qualifier.sv
verif/tb_top.sv
